// ----- hw/rtl/best_fit_heap_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the heap allocator
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define BFH_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define BFH_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define BFH_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/bfh_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap allocator package
// Shared types and status codes.
// ----------------------------------------------------------------------------
package bfh_pkg;
  localparam int AW = 13;
  localparam int LW = 17;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE, OP_SHL, OP_SHR, OP_SETLEN, OP_MERGE
  } op_e_t;

  typedef struct packed {
    op_e_t          op;
    logic [7:0]     idx;
    logic [AW-1:0]  start;
    logic [LW-1:0]  len;
  } cell_cmd_t;
endpackage

// ----- hw/rtl/best_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// Best-fit heap allocator
// ----------------------------------------------------------------------------
// Command interface: drive in_mode/in_req_size/in_user_addr with start high
// while busy is low; the word is taken on that edge. Mode 0 allocates
// in_req_size bytes, mode 1 frees in_user_addr. Each request yields one
// result word on out_grant_addr/out_granted/out_status, shown for one cycle
// with out_valid high; the receiver cannot stall it.
// The free table is a row of cells that shift left or right one slot per
// command. A request walks the live table, then the free table one entry a
// cycle. An alloc that fits takes one fit pass; an alloc that grows the heap
// takes a fit pass, an insert pass and a second fit pass; a free of a live
// block takes an insert pass. Null frees and zero or oversize allocs skip the
// scans and go straight to the result. busy drops in the out_valid cycle, so
// the next word can be taken on the edge that ends that cycle.
// Reset clears the free count, the chunk count and all live valid bits;
// cfg_chunk_limit resets to 4 and is written with cfg_we. The user is to
// write it with cfg_we only while idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
`include "best_fit_heap_allocator_assert.svh"
module best_fit_heap_allocator import bfh_pkg::*; #(
  parameter int CHUNK_BYTES  = 2048,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_CHUNKS   = 4,
  parameter int FREE_ENTRIES = 16,
  parameter int LIVE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_req_size,
  input  logic [12:0] in_user_addr,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_chunk_limit,
  output logic        out_valid,
  output logic [12:0] out_grant_addr,
  output logic        out_granted,
  output logic [1:0]  out_status
);
  localparam int FIW = $clog2(FREE_ENTRIES);
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int LIW = $clog2(LIVE_ENTRIES);
  localparam int LCW = $clog2(LIVE_ENTRIES + 1);
  localparam int KW  = $clog2(MAX_CHUNKS + 1) + 3;
  localparam logic [LW-1:0] HDR  = LW'(HEADER_BYTES);
  localparam logic [LW-1:0] CPAY = LW'(CHUNK_BYTES - HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_LSCAN, S_FSCAN, S_FIT, S_GROW, S_INS_SCAN, S_INS, S_APPLY,
    S_LIVE_WR, S_DONE
  } state_t;

  state_t state_r;
  logic mode_r;
  logic [15:0] size_r;
  logic [AW-1:0] uaddr_r;
  logic [2:0] limit_r;
  logic [FCW-1:0] fcount_r;
  logic [KW-1:0] chunks_r;
  logic [LIVE_ENTRIES-1:0] lvalid_r;
  logic [LCW-1:0] lptr_r;
  logic [LIW-1:0] slot_r;
  logic slot_ok_r, hit_r;
  logic [FCW-1:0] fptr_r, best_r;
  logic exact_r, best_ok_r;
  logic [AW-1:0] ins_hdr_r;
  logic [LW-1:0] ins_len_r;
  logic grown_r;
  logic [AW-1:0] grant_r;
  logic [1:0] stat_r;
  logic ins_from_grow_r;
  logic [AW-1:0] live_hdr_r;
  logic [LW-1:0] live_len_r;
  cell_cmd_t cmd;

  logic [AW-1:0] fs [FREE_ENTRIES];
  logic [LW-1:0] fl [FREE_ENTRIES];

  logic [AW-1:0] ls_mem [LIVE_ENTRIES];
  logic [LW-1:0] ll_mem [LIVE_ENTRIES];

  genvar g;
  generate
    for (g = 0; g < FREE_ENTRIES; g++) begin : g_cell
      bfh_cell #(.IW(FIW)) u_cell (
        .clk(clk), .my_idx(FIW'(g)), .cmd(cmd),
        .left_start(fs[(g == 0) ? 0 : g - 1]), .left_len(fl[(g == 0) ? 0 : g - 1]),
        .right_start(fs[(g == FREE_ENTRIES - 1) ? g : g + 1]),
        .right_len(fl[(g == FREE_ENTRIES - 1) ? g : g + 1]),
        .start_r(fs[g]), .len_r(fl[g])
      );
    end
  endgenerate

  logic [FIW-1:0] fi, bi, fim1;
  logic [AW-1:0] cur_s, best_s, prev_s;
  logic [LW-1:0] cur_l, best_l, prev_l;
  logic [LW-1:0] need;
  logic [LIW-1:0] li;
  assign fi = fptr_r[FIW-1:0];
  assign fim1 = fi - 1'b1;
  assign bi = best_r[FIW-1:0];
  assign cur_s = fs[fi];
  assign cur_l = fl[fi];
  assign prev_s = fs[fim1];
  assign prev_l = fl[fim1];
  assign best_s = fs[bi];
  assign best_l = fl[bi];
  assign need = LW'(size_r) + HDR;
  assign li = lptr_r[LIW-1:0];

  logic lm, rm;
  assign lm = (fptr_r != '0) && (LW'(prev_s) + HDR + prev_l == LW'(ins_hdr_r));
  assign rm = (fptr_r < fcount_r) && (LW'(ins_hdr_r) + HDR + ins_len_r == LW'(cur_s));

  logic [KW-1:0] lim_eff;
  assign lim_eff = (KW'(limit_r) < KW'(MAX_CHUNKS)) ? KW'(limit_r) : KW'(MAX_CHUNKS);

  always_comb begin
    cmd = '0;
    cmd.op = OP_NONE;
    if (state_r == S_INS) begin
      cmd.idx = 8'(fptr_r);
      if (lm && rm) begin
        cmd.op = OP_MERGE;
        cmd.idx = 8'(fptr_r - 1'b1);
        cmd.start = prev_s;
        cmd.len = prev_l + HDR + ins_len_r + HDR + cur_l;
      end else if (lm) begin
        cmd.op = OP_SETLEN;
        cmd.idx = 8'(fptr_r - 1'b1);
        cmd.start = prev_s;
        cmd.len = prev_l + HDR + ins_len_r;
      end else if (rm) begin
        cmd.op = OP_SETLEN;
        cmd.start = ins_hdr_r;
        cmd.len = cur_l + HDR + ins_len_r;
      end else if (fcount_r < FCW'(FREE_ENTRIES)) begin
        cmd.op = OP_SHR;
        cmd.start = ins_hdr_r;
        cmd.len = ins_len_r;
      end
    end else if (state_r == S_APPLY) begin
      cmd.idx = 8'(best_r);
      if (best_l >= need + 1'b1) begin
        cmd.op = OP_SETLEN;
        cmd.start = best_s;
        cmd.len = best_l - need;
      end else begin
        cmd.op = OP_SHL;
      end
    end else if (state_r == S_INS_SCAN && lm && rm) begin
      cmd.op = OP_NONE;
    end
  end

  logic [AW-1:0] rd_s;
  logic [LW-1:0] rd_l;
  always_ff @(posedge clk) begin
    rd_s <= ls_mem[li];
    rd_l <= ll_mem[li];
    if (state_r == S_LIVE_WR && !mode_r) begin
      ls_mem[slot_r] <= live_hdr_r;
      ll_mem[slot_r] <= live_len_r;
    end
  end

  logic rd_v_r;
  logic [LIW-1:0] rd_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= 3'd4;
      fcount_r <= '0;
      chunks_r <= '0;
      lvalid_r <= '0;
      out_valid <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      rd_v_r <= 1'b0;
      if (cfg_we) limit_r <= cfg_chunk_limit;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            size_r <= in_req_size;
            uaddr_r <= in_user_addr;
            lptr_r <= '0;
            slot_ok_r <= 1'b0;
            hit_r <= 1'b0;
            grant_r <= '0;
            stat_r <= ST_OK;
            grown_r <= 1'b0;
            if (!in_mode && 32'(in_req_size) > 32'(CHUNK_BYTES - HEADER_BYTES)) begin
              stat_r <= ST_TOO_LARGE;
              state_r <= S_DONE;
            end else if ((!in_mode && in_req_size == '0) || (in_mode && in_user_addr == '0))
              state_r <= S_DONE;
            else state_r <= S_LSCAN;
          end
        end
        S_LSCAN: begin
          if (lptr_r < LCW'(LIVE_ENTRIES)) begin
            lptr_r <= lptr_r + 1'b1;
            rd_v_r <= 1'b1;
            rd_i_r <= li;
          end
          if (!mode_r) begin
            if (lptr_r < LCW'(LIVE_ENTRIES) && !lvalid_r[li] && !slot_ok_r) begin
              slot_ok_r <= 1'b1;
              slot_r <= li;
            end
          end else if (rd_v_r && !hit_r && lvalid_r[rd_i_r]
                       && rd_s + AW'(HEADER_BYTES) == uaddr_r) begin
            hit_r <= 1'b1;
            slot_r <= rd_i_r;
            ins_hdr_r <= rd_s;
            ins_len_r <= rd_l;
          end
          if (lptr_r == LCW'(LIVE_ENTRIES) && !rd_v_r) begin
            fptr_r <= '0;
            if (!mode_r) begin
              if (!slot_ok_r) begin
                stat_r <= ST_FULL;
                state_r <= S_DONE;
              end else begin
                best_ok_r <= 1'b0;
                exact_r <= 1'b0;
                state_r <= S_FSCAN;
              end
            end else if (!hit_r) state_r <= S_DONE;
            else begin
              ins_from_grow_r <= 1'b0;
              state_r <= S_INS_SCAN;
            end
          end
        end
        S_FSCAN: begin
          if (fptr_r < fcount_r && !exact_r) begin
            fptr_r <= fptr_r + 1'b1;
            if (cur_l == LW'(size_r)) begin
              exact_r <= 1'b1;
              best_ok_r <= 1'b1;
              best_r <= fptr_r;
            end else if (cur_l > LW'(size_r) && (!best_ok_r || cur_l < best_l)) begin
              best_ok_r <= 1'b1;
              best_r <= fptr_r;
            end
          end else state_r <= S_FIT;
        end
        S_FIT: begin
          if (best_ok_r) state_r <= S_APPLY;
          else if (grown_r || KW'(chunks_r) >= KW'(lim_eff)) begin
            stat_r <= ST_OOM;
            state_r <= S_DONE;
          end else begin
            ins_hdr_r <= AW'(32'(chunks_r) * CHUNK_BYTES);
            ins_len_r <= CPAY;
            ins_from_grow_r <= 1'b1;
            fptr_r <= '0;
            state_r <= S_INS_SCAN;
          end
        end
        S_INS_SCAN: begin
          if (fptr_r < fcount_r && cur_s < ins_hdr_r) fptr_r <= fptr_r + 1'b1;
          else state_r <= S_INS;
        end
        S_INS: begin
          if (lm && rm) fcount_r <= fcount_r - 1'b1;
          else if (!lm && !rm) begin
            if (fcount_r < FCW'(FREE_ENTRIES)) fcount_r <= fcount_r + 1'b1;
          end
          if (!lm && !rm && fcount_r >= FCW'(FREE_ENTRIES)) begin
            stat_r <= ST_FULL;
            state_r <= S_DONE;
          end else if (ins_from_grow_r) begin
            chunks_r <= chunks_r + 1'b1;
            grown_r <= 1'b1;
            fptr_r <= '0;
            best_ok_r <= 1'b0;
            exact_r <= 1'b0;
            state_r <= S_FSCAN;
          end else begin
            lvalid_r[slot_r] <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_APPLY: begin
          if (best_l >= need + 1'b1) begin
            live_hdr_r <= AW'(LW'(best_s) + HDR + best_l - need);
            live_len_r <= LW'(size_r);
            grant_r <= AW'(LW'(best_s) + best_l - LW'(size_r) + HDR);
          end else begin
            live_hdr_r <= best_s;
            live_len_r <= best_l;
            grant_r <= best_s + AW'(HEADER_BYTES);
            fcount_r <= fcount_r - 1'b1;
          end
          state_r <= S_LIVE_WR;
        end
        S_LIVE_WR: begin
          lvalid_r[slot_r] <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_grant_addr <= grant_r;
          out_granted <= grant_r != '0;
          out_status <= stat_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = state_r != S_IDLE;

  `BFH_ASSERT_NXT(a_done_valid, clk, rst_n, state_r == S_DONE, out_valid)
  `BFH_ASSERT_IMP(a_free_nogrant, clk, rst_n, state_r == S_DONE && mode_r, grant_r == '0)
  `BFH_ASSERT_IMP(a_fcount_max, clk, rst_n, 1'b1, fcount_r <= FCW'(FREE_ENTRIES))
endmodule

// ----- hw/rtl/bfh_cell.sv -----
// ----------------------------------------------------------------------------
// Free table cell
// One entry of the sorted free table; shifts with its neighbors.
// ----------------------------------------------------------------------------
module bfh_cell import bfh_pkg::*; #(
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic [IW-1:0] my_idx,
  input  cell_cmd_t     cmd,
  input  logic [AW-1:0] left_start,
  input  logic [LW-1:0] left_len,
  input  logic [AW-1:0] right_start,
  input  logic [LW-1:0] right_len,
  output logic [AW-1:0] start_r,
  output logic [LW-1:0] len_r
);
  logic [IW-1:0] ci;
  assign ci = cmd.idx[IW-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SHR: begin
        if (my_idx > ci) begin
          start_r <= left_start;
          len_r <= left_len;
        end else if (my_idx == ci) begin
          start_r <= cmd.start;
          len_r <= cmd.len;
        end
      end
      OP_SHL: begin
        if (my_idx >= ci) begin
          start_r <= right_start;
          len_r <= right_len;
        end
      end
      OP_SETLEN: begin
        if (my_idx == ci) begin
          start_r <= cmd.start;
          len_r <= cmd.len;
        end
      end
      OP_MERGE: begin
        if (my_idx == ci) begin
          start_r <= cmd.start;
          len_r <= cmd.len;
        end else if (my_idx > ci) begin
          start_r <= right_start;
          len_r <= right_len;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- verif/best_fit_heap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit heap allocator testbench
// Drives allocate and free requests through the start/busy command port and
// checks every result word against a behavioral model of the heap: a sorted,
// coalesced free table, a table of live blocks and the chunk counter. A
// directed table covers the size and address extremes and the OK, TOO_LARGE
// and OOM codes, a table fill FULL; random phases use several chunk limits.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_tb import bfh_pkg::*; ();

  localparam int CHUNK_B  = 2048;
  localparam int HDR_B    = 16;
  localparam int MAX_CH   = 4;
  localparam int FREE_N   = 16;
  localparam int LIVE_N   = 32;
  localparam int LATENCY  = LIVE_N + 3 * FREE_N + 11;
  localparam int MAX_CYC  = 1000000;
  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_FREE  = 1'b1;

  typedef struct {
    logic [12:0] addr;
    logic        granted;
    logic [1:0]  status;
  } grant_word_t;

  typedef struct {
    bit          mode;
    logic [15:0] size;
    logic [12:0] uaddr;
    bit          fixed;
    grant_word_t want;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [15:0] in_req_size = '0;
  logic [12:0] in_user_addr = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_chunk_limit = 3'd4;
  logic        out_valid;
  logic [12:0] out_grant_addr;
  logic        out_granted;
  logic [1:0]  out_status;

  int unsigned hp_fstart [FREE_N];
  int unsigned hp_flen   [FREE_N];
  int unsigned hp_fcount;
  int unsigned hp_lstart [LIVE_N];
  int unsigned hp_llen   [LIVE_N];
  bit          hp_lvalid [LIVE_N];
  int unsigned hp_chunks;
  int unsigned hp_limit;

  grant_word_t pending_grants[$];
  int          mismatches;
  int          cycles;
  req_row_t    dir_rows[$];

  best_fit_heap_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_req_size     (in_req_size),
    .in_user_addr    (in_user_addr),
    .cfg_we          (cfg_we),
    .cfg_chunk_limit (cfg_chunk_limit),
    .out_valid       (out_valid),
    .out_grant_addr  (out_grant_addr),
    .out_granted     (out_granted),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  function automatic void heap_drop(int unsigned i);
    for (int unsigned k = i; k + 1 < hp_fcount; k++) begin
      hp_fstart[k] = hp_fstart[k + 1];
      hp_flen[k]   = hp_flen[k + 1];
    end
    hp_fcount--;
  endfunction

  function automatic bit heap_insert(int unsigned hdr, int unsigned len);
    int unsigned p;
    bit lm, rm;
    p = 0;
    while (p < hp_fcount && hp_fstart[p] < hdr) p++;
    lm = p > 0 && hp_fstart[p - 1] + HDR_B + hp_flen[p - 1] == hdr;
    rm = p < hp_fcount && hdr + HDR_B + len == hp_fstart[p];
    if (lm && rm) begin
      hp_flen[p - 1] += HDR_B + len + HDR_B + hp_flen[p];
      heap_drop(p);
    end else if (lm) begin
      hp_flen[p - 1] += HDR_B + len;
    end else if (rm) begin
      hp_fstart[p] = hdr;
      hp_flen[p] += HDR_B + len;
    end else begin
      if (hp_fcount >= FREE_N) return 1'b0;
      for (int unsigned k = hp_fcount; k > p; k--) begin
        hp_fstart[k] = hp_fstart[k - 1];
        hp_flen[k]   = hp_flen[k - 1];
      end
      hp_fstart[p] = hdr;
      hp_flen[p]   = len;
      hp_fcount++;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned heap_best_fit(int unsigned size);
    int unsigned best;
    best = hp_fcount;
    for (int unsigned i = 0; i < hp_fcount; i++)
      if (hp_flen[i] == size) return i;
    for (int unsigned i = 0; i < hp_fcount; i++)
      if (hp_flen[i] > size && (best == hp_fcount || hp_flen[i] < hp_flen[best])) best = i;
    return best;
  endfunction

  function automatic logic [1:0] heap_alloc(int unsigned size, output int unsigned grant);
    int unsigned slot, b, lim, hdr, len;
    grant = 0;
    if (size > CHUNK_B - HDR_B) return ST_TOO_LARGE;
    if (size == 0) return ST_OK;
    slot = 0;
    while (slot < LIVE_N && hp_lvalid[slot]) slot++;
    if (slot >= LIVE_N) return ST_FULL;
    b = heap_best_fit(size);
    if (b >= hp_fcount) begin
      lim = hp_limit < MAX_CH ? hp_limit : MAX_CH;
      if (hp_chunks >= lim) return ST_OOM;
      if (!heap_insert(hp_chunks * CHUNK_B, CHUNK_B - HDR_B)) return ST_FULL;
      hp_chunks++;
      b = heap_best_fit(size);
      if (b >= hp_fcount) return ST_OOM;
    end
    if (hp_flen[b] >= size + HDR_B + 1) begin
      hdr = hp_fstart[b] + HDR_B + hp_flen[b] - (size + HDR_B);
      hp_flen[b] -= size + HDR_B;
      len = size;
    end else begin
      hdr = hp_fstart[b];
      len = hp_flen[b];
      heap_drop(b);
    end
    hp_lstart[slot] = hdr;
    hp_llen[slot]   = len;
    hp_lvalid[slot] = 1'b1;
    grant = hdr + HDR_B;
    return ST_OK;
  endfunction

  function automatic logic [1:0] heap_free(int unsigned uaddr);
    int unsigned i;
    if (uaddr == 0) return ST_OK;
    i = 0;
    while (i < LIVE_N && !(hp_lvalid[i] && hp_lstart[i] + HDR_B == uaddr)) i++;
    if (i >= LIVE_N) return ST_OK;
    if (!heap_insert(hp_lstart[i], hp_llen[i])) return ST_FULL;
    hp_lvalid[i] = 1'b0;
    return ST_OK;
  endfunction

  function automatic grant_word_t heap_serve(bit mode, logic [15:0] size, logic [12:0] uaddr);
    grant_word_t w;
    int unsigned g;
    g = 0;
    if (mode == MODE_ALLOC) w.status = heap_alloc(size, g);
    else w.status = heap_free(uaddr);
    w.addr    = g[12:0];
    w.granted = g != 0;
    return w;
  endfunction

  function automatic logic [12:0] pick_live_addr();
    int unsigned n, k;
    n = 0;
    for (int i = 0; i < LIVE_N; i++) if (hp_lvalid[i]) n++;
    if (n == 0) return 13'd0;
    k = $urandom_range(n - 1);
    for (int i = 0; i < LIVE_N; i++)
      if (hp_lvalid[i]) begin
        if (k == 0) return 13'(hp_lstart[i] + HDR_B);
        k--;
      end
    return 13'd0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word addr=%0d granted=%0b status=%0d",
                                       out_grant_addr, out_granted, out_status);
      end else begin
        grant_word_t w;
        w = pending_grants.pop_front();
        if (out_grant_addr !== w.addr || out_granted !== w.granted ||
            out_status !== w.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr=%0d granted=%0b status=%0d, got %0d %0b %0d",
                     w.addr, w.granted, w.status, out_grant_addr, out_granted, out_status);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(2);
    repeat (n) @(posedge clk);
  endtask

  task automatic issue(bit mode, logic [15:0] size, logic [12:0] uaddr, bit gaps,
                       output grant_word_t w);
    w = heap_serve(mode, size, uaddr);
    pending_grants.push_back(w);
    start        <= 1'b1;
    in_mode      <= mode;
    in_req_size  <= size;
    in_user_addr <= uaddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
    if (gaps) idle_gap();
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] v);
    cfg_we          <= 1'b1;
    cfg_chunk_limit <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hp_limit = v;
  endtask

  function automatic void add_row(bit mode, logic [15:0] size, logic [12:0] uaddr,
                                  bit fixed, logic [12:0] a, bit g, logic [1:0] s);
    req_row_t r;
    r.mode = mode; r.size = size; r.uaddr = uaddr; r.fixed = fixed;
    r.want.addr = a; r.want.granted = g; r.want.status = s;
    dir_rows.push_back(r);
  endfunction

  task automatic random_phase(int n);
    grant_word_t w;
    logic [15:0] sz;
    logic [12:0] ua;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 60) sz = 16'($urandom_range(1, 200));
        else if (r < 85) sz = 16'($urandom_range(1, CHUNK_B - HDR_B));
        else if (r < 90) sz = 16'd0;
        else sz = 16'($urandom);
        issue(MODE_ALLOC, sz, '0, 1'b1, w);
      end else begin
        r = $urandom_range(99);
        if (r < 85) ua = pick_live_addr();
        else ua = 13'($urandom);
        issue(MODE_FREE, '0, ua, 1'b1, w);
      end
    end
  endtask

  initial begin
    grant_word_t w;
    int unsigned lims[5] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd4};
    mismatches = 0;
    cycles = 0;
    hp_fcount = 0; hp_chunks = 0; hp_limit = 4;
    for (int i = 0; i < LIVE_N; i++) hp_lvalid[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(MODE_FREE,  16'd0,     13'd0,    1, 13'd0, 0, ST_OK);
    add_row(MODE_FREE,  16'd0,     13'h1FFF, 1, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd0,     13'd0,    1, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'hFFFF,  13'd0,    1, 13'd0, 0, ST_TOO_LARGE);
    add_row(MODE_ALLOC, 16'd2033,  13'd0,    1, 13'd0, 0, ST_TOO_LARGE);
    add_row(MODE_ALLOC, 16'd2032,  13'd0,    1, 13'd16, 1, ST_OK);
    add_row(MODE_ALLOC, 16'd100,   13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd2016,  13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd1,     13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_FREE,  16'd0,     13'd16,   1, 13'd0, 0, ST_OK);
    add_row(MODE_FREE,  16'd0,     13'd16,   1, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd2032,  13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd2032,  13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd2032,  13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd2032,  13'd0,    0, 13'd0, 0, ST_OK);
    add_row(MODE_ALLOC, 16'd5555,  13'd0,    0, 13'd0, 0, ST_OK);
    foreach (dir_rows[i]) begin
      issue(dir_rows[i].mode, dir_rows[i].size, dir_rows[i].uaddr, 1'b0, w);
      if (dir_rows[i].fixed && (w.addr !== dir_rows[i].want.addr ||
          w.granted !== dir_rows[i].want.granted || w.status !== dir_rows[i].want.status)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: exp addr=%0d granted=%0b status=%0d, got %0d %0b %0d",
                   i, dir_rows[i].want.addr, dir_rows[i].want.granted,
                   dir_rows[i].want.status, w.addr, w.granted, w.status);
      end
    end
    // fill the live table, then check the full case
    for (int i = 0; i < LIVE_N + 2; i++) issue(MODE_ALLOC, 16'd8, '0, 1'b0, w);
    drain();

    foreach (lims[p]) begin
      write_limit(3'(lims[p]));
      random_phase(230);
      // hold off until no result word is outstanding
      drain();
      for (int i = 0; i < LIVE_N; i++)
        if (hp_lvalid[i]) issue(MODE_FREE, '0, 13'(hp_lstart[i] + HDR_B), 1'b0, w);
      drain();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
